// File: hdl/assert_macros.svh
// Assertion macros shared by the speed limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: hdl/mwsl_pkg.sv
// Types and constants shared by the mecanum wheel speed limiter modules.
package mwsl_pkg;

  localparam int SPD_W      = 16;            // Q3.12 speed and gain words
  localparam int FRAC_W     = 12;            // fraction bits
  localparam int PROD_W     = 2 * SPD_W;     // gain * yaw product
  localparam int WHL_W      = 20;            // exact wheel sums
  localparam int MAG_W      = 19;            // wheel magnitudes
  localparam int LIM_W      = 15;            // speed limit
  localparam int QUO_W      = LIM_W;         // scaled magnitude never exceeds the limit
  localparam int NUM_W      = MAG_W + LIM_W; // magnitude * limit
  localparam int NUM_WHEELS = 4;
  localparam int CFG_IDX_W  = 2;
  // yaw products, sums, magnitudes, max/numerators, divider steps, output
  localparam int LATENCY    = 4 + QUO_W + 1;

  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic signed [WHL_W-1:0] wheel_t;
  typedef logic        [MAG_W-1:0] mag_t;
  typedef logic        [LIM_W-1:0] lim_t;
  typedef logic        [NUM_W-1:0] num_t;
  typedef logic        [QUO_W-1:0] quo_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_GAIN  = 2'd0,
    REG_REAR_GAIN   = 2'd1,
    REG_SPEED_LIMIT = 2'd2
  } cfg_reg_e;

  localparam spd_t FRONT_GAIN_RST = -16'sd737;
  localparam spd_t REAR_GAIN_RST  = -16'sd901;
  localparam lim_t SPEED_LIM_RST  = 15'd13107;

  typedef struct packed {
    spd_t front_gain;
    spd_t rear_gain;
    lim_t limit;
  } cfg_t;

  // wheel sums leaving the kinematics stages
  typedef struct packed {
    logic                         valid;
    wheel_t [NUM_WHEELS-1:0]      wheel;
  } kin_t;

  // request entering the divider array
  typedef struct packed {
    logic                         valid;
    logic                         limited;
    logic   [NUM_WHEELS-1:0]      neg;
    spd_t   [NUM_WHEELS-1:0]      wlo;
    mag_t                         divisor;
    num_t   [NUM_WHEELS-1:0]      num;
  } norm_t;

  // request leaving the divider array
  typedef struct packed {
    logic                         valid;
    logic                         limited;
    logic   [NUM_WHEELS-1:0]      neg;
    spd_t   [NUM_WHEELS-1:0]      wlo;
    quo_t   [NUM_WHEELS-1:0]      quo;
  } scale_t;

endpackage

// File: hdl/mwsl_kin.sv
// Mecanum inverse kinematics: yaw products, then the four wheel sums.
module mwsl_kin import mwsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  spd_t fwd_i,
  input  spd_t side_i,
  input  spd_t yaw_i,
  input  cfg_t cfg_i,
  output kin_t kin_o
);

  logic                     prod_vld_q;
  spd_t                     fwd_q, side_q;
  logic signed [PROD_W-1:0] prod_f_q, prod_r_q;
  logic                     kin_vld_q;
  wheel_t [NUM_WHEELS-1:0]  wheel_q, wheel_d;

  wheel_t fwd_x, side_x, yaw_f, yaw_r;

  // Stage 1: yaw products
  always_ff @(posedge clk_i) begin
    fwd_q    <= fwd_i;
    side_q   <= side_i;
    prod_f_q <= cfg_i.front_gain * yaw_i;
    prod_r_q <= cfg_i.rear_gain * yaw_i;
  end

  // Stage 2: floor shift and sums
  always_comb begin
    fwd_x      = wheel_t'(fwd_q);
    side_x     = wheel_t'(side_q);
    yaw_f      = prod_f_q[FRAC_W+WHL_W-1:FRAC_W];
    yaw_r      = prod_r_q[FRAC_W+WHL_W-1:FRAC_W];
    wheel_d[0] =  fwd_x - side_x + yaw_f;
    wheel_d[1] = -fwd_x - side_x + yaw_f;
    wheel_d[2] =  fwd_x + side_x + yaw_r;
    wheel_d[3] = -fwd_x + side_x + yaw_r;
  end

  always_ff @(posedge clk_i) begin
    wheel_q <= wheel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      kin_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      kin_vld_q  <= prod_vld_q;
    end
  end

  assign kin_o.valid = kin_vld_q;
  assign kin_o.wheel = wheel_q;

endmodule

// File: hdl/mwsl_norm.sv
// Wheel magnitudes, largest magnitude, limit check and scaled numerators.
module mwsl_norm import mwsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  kin_t  kin_i,
  input  lim_t  limit_i,
  output norm_t norm_o
);

  logic                     mag_vld_q;
  mag_t [NUM_WHEELS-1:0]    mag_q, mag_d;
  logic [NUM_WHEELS-1:0]    neg_q, neg_d;
  spd_t [NUM_WHEELS-1:0]    wlo_q, wlo_d;

  logic                     out_vld_q;
  logic                     limited_q;
  logic [NUM_WHEELS-1:0]    neg2_q;
  spd_t [NUM_WHEELS-1:0]    wlo2_q;
  mag_t                     max_q;
  num_t [NUM_WHEELS-1:0]    num_q, num_d;

  wheel_t neg_w;
  mag_t   max01, max23, max_d;

  // Stage 3: magnitudes
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      neg_d[i] = kin_i.wheel[i][WHL_W-1];
      neg_w    = -kin_i.wheel[i];
      mag_d[i] = neg_d[i] ? neg_w[MAG_W-1:0] : kin_i.wheel[i][MAG_W-1:0];
      wlo_d[i] = kin_i.wheel[i][SPD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    wlo_q <= wlo_d;
  end

  // Stage 4: max tree alongside the numerator products
  always_comb begin
    max01 = (mag_q[0] >= mag_q[1]) ? mag_q[0] : mag_q[1];
    max23 = (mag_q[2] >= mag_q[3]) ? mag_q[2] : mag_q[3];
    max_d = (max01 >= max23) ? max01 : max23;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      num_d[i] = NUM_W'(mag_q[i]) * NUM_W'(limit_i);
    end
  end

  always_ff @(posedge clk_i) begin
    max_q     <= max_d;
    limited_q <= max_d > MAG_W'(limit_i);
    num_q     <= num_d;
    neg2_q    <= neg_q;
    wlo2_q    <= wlo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mag_vld_q <= kin_i.valid;
      out_vld_q <= mag_vld_q;
    end
  end

  assign norm_o.valid   = out_vld_q;
  assign norm_o.limited = limited_q;
  assign norm_o.neg     = neg2_q;
  assign norm_o.wlo     = wlo2_q;
  assign norm_o.divisor = max_q;
  assign norm_o.num     = num_q;

endmodule

// File: hdl/mwsl_scale.sv
// Pipelined restoring dividers, one quotient bit per stage, four wheels in parallel.
module mwsl_scale import mwsl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  norm_t  norm_i,
  output scale_t scale_o
);

  typedef struct packed {
    logic                    limited;
    logic [NUM_WHEELS-1:0]   neg;
    spd_t [NUM_WHEELS-1:0]   wlo;
    mag_t                    divisor;
    mag_t [NUM_WHEELS-1:0]   rem;
    quo_t [NUM_WHEELS-1:0]   low;
    quo_t [NUM_WHEELS-1:0]   quo;
  } div_stage_t;

  div_stage_t             st_in;
  div_stage_t             st_q [QUO_W];
  div_stage_t             st_d [QUO_W];
  logic [QUO_W-1:0]       vld_q;

  // Numerator upper bits are below the divisor whenever scaling applies.
  always_comb begin
    st_in.limited = norm_i.limited;
    st_in.neg     = norm_i.neg;
    st_in.wlo     = norm_i.wlo;
    st_in.divisor = norm_i.divisor;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      st_in.rem[i] = norm_i.num[i][NUM_W-1:QUO_W];
      st_in.low[i] = norm_i.num[i][QUO_W-1:0];
      st_in.quo[i] = '0;
    end
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int Bit = QUO_W - 1 - s;
    div_stage_t       cur;
    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;

    if (s == 0) begin : g_first
      assign cur = st_in;
    end else begin : g_next
      assign cur = st_q[s-1];
    end

    always_comb begin
      st_d[s] = cur;
      trial   = '0;
      diff    = '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        trial = {cur.rem[i], cur.low[i][Bit]};
        diff  = trial - {1'b0, cur.divisor};
        if (trial >= {1'b0, cur.divisor}) begin
          st_d[s].rem[i]      = diff[MAG_W-1:0];
          st_d[s].quo[i][Bit] = 1'b1;
        end else begin
          st_d[s].rem[i]      = trial[MAG_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= st_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QUO_W-2:0], norm_i.valid};
    end
  end

  assign scale_o.valid   = vld_q[QUO_W-1];
  assign scale_o.limited = st_q[QUO_W-1].limited;
  assign scale_o.neg     = st_q[QUO_W-1].neg;
  assign scale_o.wlo     = st_q[QUO_W-1].wlo;
  assign scale_o.quo     = st_q[QUO_W-1].quo;

endmodule

// File: hdl/mecanum_wheel_speed_limiter_top.sv
// Top level of the mecanum wheel speed limiter: config registers, pipeline, result register.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+--------------------------------------------
//   command   | start_i, busy_o             | forward_speed_i, sideways_speed_i, yaw_rate_i
//   result    | done_o (one-cycle strobe)   | wheel_*_o, was_limited_o
//   config    | cfg_valid_i, cfg_ready_o    | cfg_index_i, cfg_wdata_i
//
// One request per cycle; a request travels from start_i to done_o through
// 2 kinematics stages, 2 magnitude/max stages, 15 divider stages (one quotient
// bit each, four wheels in parallel) and the result register.
// busy_o stays low; the pipeline never stalls since results cannot be held off.
// rst_ni clears all valid bits asynchronously; config returns to its reset values.
// Config is expected to change only while no request is in flight.

`include "assert_macros.svh"

module mecanum_wheel_speed_limiter_top import mwsl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command
  input  logic                 start_i,
  output logic                 busy_o,
  input  spd_t                 forward_speed_i,
  input  spd_t                 sideways_speed_i,
  input  spd_t                 yaw_rate_i,
  // result
  output logic                 done_o,
  output spd_t                 wheel_front_a_o,
  output spd_t                 wheel_front_b_o,
  output spd_t                 wheel_rear_a_o,
  output spd_t                 wheel_rear_b_o,
  output logic                 was_limited_o,
  // config
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SPD_W-1:0]     cfg_wdata_i
);

  cfg_t                    cfg_q, cfg_d;
  kin_t                    kin;
  norm_t                   norm;
  scale_t                  scale;

  logic                    done_q;
  logic                    limited_q;
  spd_t [NUM_WHEELS-1:0]   wheel_q, wheel_d;
  logic [SPD_W-1:0]        quo_x;
  spd_t                    lim_s;

  logic                    lim_hit;
  logic                    wfa_in_lim;
  logic                    wrb_in_lim;
  logic                    wheel_nz;
  logic                    zero_lim_pass;
  logic                    lim_wr;
  lim_t                    lim_wdata;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRONT_GAIN:  cfg_d.front_gain = cfg_wdata_i;
        REG_REAR_GAIN:   cfg_d.rear_gain  = cfg_wdata_i;
        REG_SPEED_LIMIT: cfg_d.limit      = cfg_wdata_i[LIM_W-1:0];
        default:         cfg_d            = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_gain <= FRONT_GAIN_RST;
      cfg_q.rear_gain  <= REAR_GAIN_RST;
      cfg_q.limit      <= SPEED_LIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------- datapath
  mwsl_kin u_kin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start_i && !busy_o),
    .fwd_i  (forward_speed_i),
    .side_i (sideways_speed_i),
    .yaw_i  (yaw_rate_i),
    .cfg_i  (cfg_q),
    .kin_o  (kin)
  );

  mwsl_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kin_i  (kin),
    .limit_i(cfg_q.limit),
    .norm_o (norm)
  );

  mwsl_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .norm_i (norm),
    .scale_o(scale)
  );

  // ---------------------------------------------------------------- result
  // Scaled wheels take the sign back (truncation toward zero); unscaled
  // wheels already fit in 16 bits.
  always_comb begin
    quo_x = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      quo_x = {1'b0, scale.quo[i]};
      if (!scale.limited) begin
        wheel_d[i] = scale.wlo[i];
      end else if (scale.neg[i]) begin
        wheel_d[i] = spd_t'(-quo_x);
      end else begin
        wheel_d[i] = spd_t'(quo_x);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wheel_q   <= wheel_d;
    limited_q <= scale.limited;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= scale.valid;
    end
  end

  assign done_o          = done_q;
  assign wheel_front_a_o = wheel_q[0];
  assign wheel_front_b_o = wheel_q[1];
  assign wheel_rear_a_o  = wheel_q[2];
  assign wheel_rear_b_o  = wheel_q[3];
  assign was_limited_o   = limited_q;

  // ---------------------------------------------------------------- checks
  assign lim_s         = spd_t'({1'b0, cfg_q.limit});
  assign lim_hit       = done_q && limited_q;
  assign wfa_in_lim    = (wheel_q[0] <= lim_s) && (wheel_q[0] >= -lim_s);
  assign wrb_in_lim    = (wheel_q[3] <= lim_s) && (wheel_q[3] >= -lim_s);
  assign wheel_nz      = (wheel_q[0] != '0) || (wheel_q[1] != '0) ||
                         (wheel_q[2] != '0) || (wheel_q[3] != '0);
  assign zero_lim_pass = done_q && !limited_q && (cfg_q.limit == '0) && wheel_nz;
  assign lim_wr        = cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_SPEED_LIMIT);
  assign lim_wdata     = cfg_wdata_i[LIM_W-1:0];

  `ASSERT_PROP(a_done_latency, clk_i, rst_ni, done_q |-> $past(start_i, LATENCY), "stray result")

  `ASSERT_PROP(a_lim_front_a, clk_i, rst_ni, lim_hit |-> wfa_in_lim, "scaled wheel 0 above limit")

  `ASSERT_PROP(a_lim_rear_b, clk_i, rst_ni, lim_hit |-> wrb_in_lim, "scaled wheel 3 above limit")

  `ASSERT_NEVER(a_zero_lim, clk_i, rst_ni, zero_lim_pass, "nonzero wheel passed a zero limit")

  `ASSERT_PROP(a_cfg_limit, clk_i, rst_ni, lim_wr |=> (cfg_q.limit == $past(lim_wdata)), "limit lost")

endmodule

// File: tb/mecanum_wheel_speed_limiter_top_test.sv
// Testbench for the mecanum wheel speed limiter: directed and random commands against a predictor.
`timescale 1ns / 1ps

module mecanum_wheel_speed_limiter_top_test;
  import mwsl_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam spd_t SPD_MAX = 16'sh7FFF;
  localparam spd_t SPD_MIN = 16'sh8000;
  // index 3 has no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 9;
  localparam int IDLE_PCT        = 33;
  localparam int DRAIN_LIMIT     = LATENCY * 50;

  localparam string WHEEL_PORT [NUM_WHEELS] =
    '{"wheel_front_a", "wheel_front_b", "wheel_rear_a", "wheel_rear_b"};

  // one result request: four setpoints and the limit flag
  typedef struct packed {
    spd_t [NUM_WHEELS-1:0] wheel;
    logic                  limited;
  } setpoint_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: shadow config, expected setpoints in request order
  // ---------------------------------------------------------------------------
  class setpoint_checker;
    spd_t        front_gain;
    spd_t        rear_gain;
    lim_t        limit;
    setpoint_t   pending[$];
    int unsigned mismatches;

    function new();
      front_gain = FRONT_GAIN_RST;
      rear_gain  = REAR_GAIN_RST;
      limit      = SPEED_LIM_RST;
      mismatches = 0;
    endfunction

    // mirror an accepted config write; unknown indexes are dropped
    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SPD_W-1:0] data);
      case (idx)
        REG_FRONT_GAIN:  front_gain = data;
        REG_REAR_GAIN:   rear_gain  = data;
        REG_SPEED_LIMIT: limit      = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // inverse kinematics, then scale all wheels by limit/max if max > limit
    function setpoint_t limit_wheel_speeds(spd_t fwd, spd_t side, spd_t yaw);
      setpoint_t sp;
      longint    yf, yr, mx, lim, m;
      longint    w [NUM_WHEELS];
      // arithmetic shift floors the Q7.24 product back to Q7.12
      yf = (longint'(front_gain) * longint'(yaw)) >>> FRAC_W;
      yr = (longint'(rear_gain) * longint'(yaw)) >>> FRAC_W;
      w[0] =  longint'(fwd) - longint'(side) + yf;
      w[1] = -longint'(fwd) - longint'(side) + yf;
      w[2] =  longint'(fwd) + longint'(side) + yr;
      w[3] = -longint'(fwd) + longint'(side) + yr;
      mx = 0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        m = (w[i] < 0) ? -w[i] : w[i];
        if (m > mx) mx = m;
      end
      lim = longint'(limit);
      sp.limited = (mx > lim);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        // signed division truncates toward zero
        if (sp.limited) w[i] = (w[i] * lim) / mx;
        sp.wheel[i] = spd_t'(w[i]);
      end
      return sp;
    endfunction

    function void note_command(spd_t fwd, spd_t side, spd_t yaw);
      pending.push_back(limit_wheel_speeds(fwd, side, yaw));
    endfunction

    function void check_result(setpoint_t seen);
      setpoint_t want;
      if (pending.size() == 0) begin
        $error("result strobe with no request pending");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (seen.wheel[i] !== want.wheel[i]) begin
          $error("%s: expected %0d, got %0d", WHEEL_PORT[i], want.wheel[i], seen.wheel[i]);
          mismatches++;
        end
      end
      if (seen.limited !== want.limited) begin
        $error("was_limited: expected %0b, got %0b", want.limited, seen.limited);
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic                 start_i = 1'b0;
  logic                 busy_o;
  spd_t                 forward_speed_i = '0;
  spd_t                 sideways_speed_i = '0;
  spd_t                 yaw_rate_i = '0;
  logic                 done_o;
  spd_t                 wheel_front_a_o;
  spd_t                 wheel_front_b_o;
  spd_t                 wheel_rear_a_o;
  spd_t                 wheel_rear_b_o;
  logic                 was_limited_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SPD_W-1:0]     cfg_wdata_i = '0;

  mecanum_wheel_speed_limiter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .forward_speed_i  (forward_speed_i),
    .sideways_speed_i (sideways_speed_i),
    .yaw_rate_i       (yaw_rate_i),
    .done_o           (done_o),
    .wheel_front_a_o  (wheel_front_a_o),
    .wheel_front_b_o  (wheel_front_b_o),
    .wheel_rear_a_o   (wheel_rear_a_o),
    .wheel_rear_b_o   (wheel_rear_b_o),
    .was_limited_o    (was_limited_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  setpoint_checker sb = new();
  bit              idle_en = 1'b1;

  // ---------------------------------------------------------------------------
  // Result monitor: done_o is a one-cycle strobe, sampled at the closing edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    setpoint_t seen;
    if (rst_ni && done_o) begin
      seen.wheel[0] = wheel_front_a_o;
      seen.wheel[1] = wheel_front_b_o;
      seen.wheel[2] = wheel_rear_a_o;
      seen.wheel[3] = wheel_rear_b_o;
      seen.limited  = was_limited_o;
      sb.check_result(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks start and end on a falling edge; each drives a signal
  // at most once per edge, so a held start_i/cfg_valid_i never glitches.
  // ---------------------------------------------------------------------------

  // one command request; random idle cycles ahead of it when idling is on
  task automatic send_command(input spd_t fwd, input spd_t side, input spd_t yaw);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      start_i <= 1'b0;
      forward_speed_i  <= spd_t'($urandom);   // junk while idle
      @(negedge clk_i);
    end
    start_i          <= 1'b1;
    forward_speed_i  <= fwd;
    sideways_speed_i <= side;
    yaw_rate_i       <= yaw;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(fwd, side, yaw);
    @(negedge clk_i);
  endtask

  // stop sending and let the pipeline empty out
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    start_i <= 1'b0;
    while (sb.pending.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (LATENCY) @(negedge clk_i);
  endtask

  // one config write; leaves cfg_valid_i high for a following write
  task automatic send_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SPD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_reg(idx, data);
    @(negedge clk_i);
  endtask

  // drain, then rewrite all three registers
  task automatic program_regs(input logic [SPD_W-1:0] front, input logic [SPD_W-1:0] rear,
                              input logic [SPD_W-1:0] lim);
    wait_drained();
    send_reg_write(REG_FRONT_GAIN, front);
    send_reg_write(REG_REAR_GAIN, rear);
    send_reg_write(REG_SPEED_LIMIT, lim);
    cfg_valid_i <= 1'b0;
  endtask

  // mix of full-range, in-limit and corner values
  function automatic spd_t pick_speed();
    case ($urandom_range(9))
      0, 1, 2, 3: return spd_t'($urandom);
      4, 5, 6, 7: return spd_t'(int'($urandom_range(0, 8191)) - 4096);
      default: begin
        case ($urandom_range(4))
          0:       return SPD_MIN;
          1:       return SPD_MAX;
          2:       return spd_t'(-1);
          3:       return spd_t'(1);
          default: return spd_t'(0);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset config
    send_command('0, '0, '0);                    // all wheels zero: no division
    send_command(SPD_MAX, '0, '0);
    send_command(SPD_MIN, '0, '0);
    send_command('0, SPD_MAX, '0);
    send_command('0, SPD_MIN, '0);
    send_command('0, '0, SPD_MAX);
    send_command('0, '0, SPD_MIN);
    send_command(SPD_MAX, SPD_MAX, SPD_MAX);
    send_command(SPD_MIN, SPD_MIN, SPD_MIN);
    send_command(SPD_MAX, SPD_MIN, SPD_MIN);
    send_command(16'sd13107, '0, '0);            // max equal to limit: untouched
    send_command(16'sd13108, '0, '0);            // just over: scaled
    send_command('0, '0, 16'sd1);                // negative yaw product floors to -1
    send_command('0, '0, -16'sd1);
    send_command(16'sd1000, -16'sd2000, 16'sd3000);
    send_command(-16'sd1, -16'sd1, -16'sd1);

    // write to the unused index must change nothing
    wait_drained();
    send_reg_write(REG_SPARE, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_command(16'sd13108, '0, '0);
    send_command('0, '0, SPD_MIN);

    // zero limit, bit 15 of the data set to check masking
    program_regs(16'h0000, 16'h0000, 16'h8000);
    send_command(16'sd5, '0, '0);                // any nonzero wheel goes to zero, flagged
    send_command('0, '0, '0);
    send_command('0, '0, SPD_MAX);               // zero gains: yaw alone gives no motion

    // random phases, each with its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       program_regs(FRONT_GAIN_RST, REAR_GAIN_RST, SPEED_LIM_RST);
        1:       program_regs(SPD_MAX, SPD_MIN, 16'h7FFF);
        2:       program_regs(SPD_MIN, SPD_MAX, 16'h0000);
        3:       program_regs(16'h0000, 16'hFFFF, 16'h0001);
        default: program_regs(SPD_W'($urandom), SPD_W'($urandom), SPD_W'($urandom));
      endcase
      idle_en = (phase != 4);                    // one long back-to-back stretch
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 6 && n == ITEMS_PER_PHASE / 2) wait_drained();
        send_command(pick_speed(), pick_speed(), pick_speed());
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
